// ----- rtl/core/tts_pkg.sv -----
// Package for the task timing statistics block: payload structs, opcodes,
// register indexes and reset constants. No dependencies.
package tts_pkg;

  localparam int unsigned NumTasksDef  = 3;
  localparam int unsigned RingDepthDef = 64;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_IDLE   = 2'd3;   // no action, answered with zeros

  localparam logic [1:0] REG_EXP0   = 2'd0;
  localparam logic [1:0] REG_EXP1   = 2'd1;
  localparam logic [1:0] REG_EXP2   = 2'd2;
  localparam logic [1:0] REG_JITTER = 2'd3;

  localparam logic [31:0] EXP0_RST   = 32'd10000;
  localparam logic [31:0] EXP1_RST   = 32'd50000;
  localparam logic [31:0] EXP2_RST   = 32'd20000;
  localparam logic [31:0] JITTER_RST = 32'd1000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  task_id;
    logic [31:0] start_stamp;
    logic [31:0] end_stamp;
  } tts_in_t;

  typedef struct packed {
    logic        task_valid;
    logic [31:0] elapsed;
    logic [31:0] min_elapsed;
    logic [31:0] max_elapsed;
    logic [31:0] avg_elapsed;
    logic [31:0] samples_seen;
    logic [31:0] violation_total;
    logic        over_limit;
    logic [31:0] peak_deviation;
  } tts_out_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]  opcode;
    logic        valid;
    logic [1:0]  task_id;
    logic [31:0] elapsed;
  } tts_cmd_t;

endpackage

// ----- rtl/core/task_timing_statistics.sv -----
// Task timing statistics, top level: config registers, front end, back end.
// An input transfer queues in the front end, then runs the back end's sequencer;
// a query walks up to min(fill+1,RING_DEPTH) ring entries of its task through one
// registered memory port. The back end takes a new item only when idle, once the
// previous result is in its output register; the front queue buffers two more.
// Reset (rst_n, synchronous): config and averages to defaults, other statistics
// cleared, queue empty.
module task_timing_statistics #(
  parameter int unsigned NUM_TASKS  = tts_pkg::NumTasksDef,
  parameter int unsigned RING_DEPTH = tts_pkg::RingDepthDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tts_pkg::tts_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tts_pkg::tts_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import tts_pkg::*;

  logic [31:0] exp0_r, exp1_r, exp2_r, jit_r;
  logic        q_valid, q_ready;
  tts_cmd_t    q_cmd;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp0_r <= EXP0_RST;
      exp1_r <= EXP1_RST;
      exp2_r <= EXP2_RST;
      jit_r  <= JITTER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EXP0:   exp0_r <= cfg_data;
        REG_EXP1:   exp1_r <= cfg_data;
        REG_EXP2:   exp2_r <= cfg_data;
        REG_JITTER: jit_r  <= cfg_data;
        default:    ;
      endcase
    end
  end

  tts_front #(.NUM_TASKS(NUM_TASKS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  tts_back #(.NUM_TASKS(NUM_TASKS), .RING_DEPTH(RING_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .exp0(exp0_r), .exp1(exp1_r), .exp2(exp2_r), .jitter(jit_r),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule

// ----- rtl/core/tts_front.sv -----
// Front end: accepts input transfers, forms elapsed time and classifies.
// Holds a two-entry command queue. Depends on tts_pkg.
module tts_front #(
  parameter int unsigned NUM_TASKS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tts_pkg::tts_in_t  in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output tts_pkg::tts_cmd_t q_cmd
);
  import tts_pkg::*;

  tts_cmd_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  tts_cmd_t   cmd;
  logic       push, pop;

  // classify the incoming item
  always_comb begin
    cmd.opcode  = in_data.opcode;
    cmd.task_id = in_data.task_id;
    cmd.valid   = ({30'd0, in_data.task_id} < NUM_TASKS);
    cmd.elapsed = in_data.end_stamp - in_data.start_stamp;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- rtl/core/tts_back.sv -----
// Back end: per-task statistics, sample ring memory, query walk, clear of all
// tasks and output register. Depends on tts_pkg.
module tts_back #(
  parameter int unsigned NUM_TASKS  = 3,
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  tts_pkg::tts_cmd_t q_cmd,
  input  logic [31:0]       exp0,
  input  logic [31:0]       exp1,
  input  logic [31:0]       exp2,
  input  logic [31:0]       jitter,
  output logic              out_valid,
  input  logic              out_ready,
  output tts_pkg::tts_out_t out_data
);
  import tts_pkg::*;

  localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);
  localparam int unsigned TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned MD = NUM_TASKS * RING_DEPTH;
  localparam int unsigned AW = (MD > 1) ? $clog2(MD) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REC  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [31:0]   min_r [NUM_TASKS];
  logic [31:0]   max_r [NUM_TASKS];
  logic [31:0]   avg_r [NUM_TASKS];
  logic [31:0]   cnt_r [NUM_TASKS];
  logic [31:0]   vio_r [NUM_TASKS];
  logic [PW-1:0] wp_r  [NUM_TASKS];
  logic [FW-1:0] fill_r[NUM_TASKS];
  logic [31:0]   ring  [MD];

  logic [2:0]    state_r;
  tts_cmd_t      cmd_r;
  logic [TW-1:0] t;
  logic [31:0]   exp_r;
  logic [FW-1:0] idx_r;
  logic [31:0]   best_r;
  logic [31:0]   rd_r;
  logic          rd_ok_r;
  logic          viol_r;
  logic          ov_r;
  tts_out_t      out_r;
  tts_out_t      out_nxt;

  assign t         = cmd_r.task_id[TW-1:0];
  assign q_ready   = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;

  function automatic logic [31:0] exp_of(input logic [1:0] id, input logic [31:0] e0,
                                         input logic [31:0] e1, input logic [31:0] e2);
    case (id)
      2'd0:    exp_of = e0;
      2'd1:    exp_of = e1;
      default: exp_of = e2;
    endcase
  endfunction

  // record arithmetic
  logic [31:0] e, overrun, avg_new;
  logic [35:0] avg_sum;
  assign e       = cmd_r.elapsed;
  assign overrun = (e > exp_r) ? e - exp_r : 32'd0;
  assign avg_sum = {avg_r[t], 4'd0} - {4'd0, avg_r[t]} + {4'd0, e};
  assign avg_new = (cnt_r[t] == 32'd0) ? e : avg_sum[35:4];

  // query deviation on registered ring data
  logic [31:0] dev;
  assign dev = (rd_r > exp_r) ? rd_r - exp_r : exp_r - rd_r;

  logic [AW-1:0] ring_addr;
  always_comb begin
    if (state_r == S_REC)
      ring_addr = AW'(t * RING_DEPTH + wp_r[t]);
    else
      ring_addr = AW'(t * RING_DEPTH + idx_r[PW-1:0]);
  end

  // ring memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (state_r == S_REC && cmd_r.valid) ring[ring_addr] <= e;
    rd_r <= ring[ring_addr];
  end

  // result fields for the item held in cmd_r
  always_comb begin
    out_nxt = '0;
    if (cmd_r.valid && cmd_r.opcode != OP_IDLE) begin
      out_nxt.task_valid      = 1'b1;
      out_nxt.min_elapsed     = min_r[t];
      out_nxt.max_elapsed     = max_r[t];
      out_nxt.avg_elapsed     = avg_r[t];
      out_nxt.samples_seen    = cnt_r[t];
      out_nxt.violation_total = vio_r[t];
      if (cmd_r.opcode == OP_RECORD) begin
        out_nxt.elapsed    = e;
        out_nxt.over_limit = viol_r;
      end
      if (cmd_r.opcode == OP_QUERY) out_nxt.peak_deviation = best_r;
    end
  end

  // sequencer and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        min_r[i]  <= '1;
        max_r[i]  <= '0;
        avg_r[i]  <= (i == 0) ? EXP0_RST : (i == 1) ? EXP1_RST : EXP2_RST;
        cnt_r[i]  <= '0;
        vio_r[i]  <= '0;
        wp_r[i]   <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      // S_OUT handles the output register itself
      if (ov_r && out_ready && state_r != S_OUT) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_cmd;
            exp_r   <= exp_of(q_cmd.task_id, exp0, exp1, exp2);
            idx_r   <= '0;
            best_r  <= '0;
            rd_ok_r <= 1'b0;
            viol_r  <= 1'b0;
            if (q_cmd.opcode == OP_CLEAR) begin
              for (int i = 0; i < NUM_TASKS; i++) begin
                min_r[i]  <= '1;
                max_r[i]  <= '0;
                avg_r[i]  <= '0;
                cnt_r[i]  <= '0;
                vio_r[i]  <= '0;
                wp_r[i]   <= '0;
                fill_r[i] <= '0;
              end
              state_r <= S_OUT;
            end else if (q_cmd.opcode == OP_RECORD && q_cmd.valid)
              state_r <= S_REC;
            else if (q_cmd.opcode == OP_QUERY && q_cmd.valid)
              state_r <= S_RD;
            else
              state_r <= S_OUT;
          end
        end
        S_REC: begin
          if (e < min_r[t]) min_r[t] <= e;
          if (e > max_r[t]) max_r[t] <= e;
          avg_r[t] <= avg_new;
          cnt_r[t] <= cnt_r[t] + 32'd1;
          viol_r   <= (overrun > jitter);
          if (overrun > jitter) vio_r[t] <= vio_r[t] + 32'd1;
          wp_r[t] <= (wp_r[t] == PW'(RING_DEPTH - 1)) ? '0 : wp_r[t] + 1'b1;
          if (fill_r[t] != FW'(RING_DEPTH)) fill_r[t] <= fill_r[t] + 1'b1;
          state_r <= S_OUT;
        end
        S_RD: begin
          // read address issued for idx_r; data valid next cycle
          rd_ok_r <= (idx_r < fill_r[t]);
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (rd_ok_r && dev > best_r) best_r <= dev;
          if (!rd_ok_r || idx_r == FW'(RING_DEPTH - 1))
            state_r <= S_OUT;
          else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_OUT: begin
          if (!ov_r || out_ready) begin
            ov_r    <= 1'b1;
            out_r   <= out_nxt;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- bench/tb_task_timing_statistics.sv -----
// Testbench for task_timing_statistics: random and directed record, query and clear
// traffic with a self-checking scoreboard. Depends on tts_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_task_timing_statistics;
  import tts_pkg::*;

  localparam logic [1:0] TASK_BAD = 2'd3;   // out of range task index
  localparam int         NTASK    = 3;
  localparam int         RDEPTH   = 64;

  // Timing statistics tracker: predicts each result and checks what the block returns
  class timing_scoreboard;
    logic [31:0] expect_cyc[NTASK];
    logic [31:0] jitter;
    logic [31:0] mn[NTASK], mx[NTASK], avg[NTASK], cnt[NTASK], viol[NTASK];
    logic [31:0] ring[NTASK][RDEPTH];
    int          wptr[NTASK], fill[NTASK];
    tts_out_t    pending_q[$];
    int          errors;

    function new();
      expect_cyc[0] = EXP0_RST;
      expect_cyc[1] = EXP1_RST;
      expect_cyc[2] = EXP2_RST;
      jitter = JITTER_RST;
      clear_all();
      for (int t = 0; t < NTASK; t++) avg[t] = expect_cyc[t];
      errors = 0;
    endfunction

    function void clear_all();
      for (int t = 0; t < NTASK; t++) begin
        mn[t] = '1; mx[t] = '0; avg[t] = '0; cnt[t] = '0; viol[t] = '0;
        wptr[t] = 0; fill[t] = 0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_EXP0:   expect_cyc[0] = val;
        REG_EXP1:   expect_cyc[1] = val;
        REG_EXP2:   expect_cyc[2] = val;
        REG_JITTER: jitter = val;
        default: ;
      endcase
    endfunction

    function void fill_stats(ref tts_out_t r, input int t);
      r.task_valid      = 1'b1;
      r.min_elapsed     = mn[t];
      r.max_elapsed     = mx[t];
      r.avg_elapsed     = avg[t];
      r.samples_seen    = cnt[t];
      r.violation_total = viol[t];
    endfunction

    // Note an accepted input transfer and queue its expected result
    function void note_input(tts_in_t x);
      tts_out_t        r;
      int              t;
      logic [31:0]     e, over, d, best;
      logic [63:0]     acc;
      r = '0;
      t = int'(x.task_id);
      if (x.opcode == OP_CLEAR) begin
        clear_all();
        if (t < NTASK) fill_stats(r, t);
      end else if (x.opcode == OP_RECORD && t < NTASK) begin
        e = x.end_stamp - x.start_stamp;
        over = (e > expect_cyc[t]) ? e - expect_cyc[t] : 32'd0;
        if (e < mn[t]) mn[t] = e;
        if (e > mx[t]) mx[t] = e;
        if (cnt[t] == 0) avg[t] = e;
        else begin
          acc = {32'd0, avg[t]} * 64'd15 + {32'd0, e};
          avg[t] = acc[35:4];
        end
        cnt[t]++;
        if (over > jitter) viol[t]++;
        ring[t][wptr[t]] = e;
        wptr[t] = (wptr[t] + 1) % RDEPTH;
        if (fill[t] < RDEPTH) fill[t]++;
        fill_stats(r, t);
        r.elapsed    = e;
        r.over_limit = over > jitter;
      end else if (x.opcode == OP_QUERY && t < NTASK) begin
        best = '0;
        for (int i = 0; i < fill[t]; i++) begin
          d = (ring[t][i] > expect_cyc[t]) ? ring[t][i] - expect_cyc[t]
                                           : expect_cyc[t] - ring[t][i];
          if (d > best) best = d;
        end
        fill_stats(r, t);
        r.peak_deviation = best;
      end
      pending_q.push_back(r);
    endfunction

    function void field_cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        if (errors <= 10)
          $display("MISMATCH %s: expected %0h, got %0h at %0t", name, exp_v, act_v, $realtime);
      end
    endfunction

    // Check one result transfer against the oldest expectation
    function void check_result(tts_out_t a);
      tts_out_t p;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("MISMATCH: result %0h with nothing expected", a);
        return;
      end
      p = pending_q.pop_front();
      field_cmp("task_valid",      p.task_valid,      a.task_valid);
      field_cmp("elapsed",         p.elapsed,         a.elapsed);
      field_cmp("min_elapsed",     p.min_elapsed,     a.min_elapsed);
      field_cmp("max_elapsed",     p.max_elapsed,     a.max_elapsed);
      field_cmp("avg_elapsed",     p.avg_elapsed,     a.avg_elapsed);
      field_cmp("samples_seen",    p.samples_seen,    a.samples_seen);
      field_cmp("violation_total", p.violation_total, a.violation_total);
      field_cmp("over_limit",      p.over_limit,      a.over_limit);
      field_cmp("peak_deviation",  p.peak_deviation,  a.peak_deviation);
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  tts_in_t     in_data;
  tts_out_t    out_data;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  timing_scoreboard sb;
  int burst_left;
  int stall_mode;

  task_timing_statistics dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Result side: check every transfer, stall on a pattern that changes over time
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Offer one item, bursts of random length with random gaps between them
  task automatic send_item(tts_in_t x);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (!in_ready);
    sb.note_input(x);
    burst_left--;
  endtask

  task automatic send_op(logic [1:0] op, logic [1:0] tid, logic [31:0] s, logic [31:0] e);
    tts_in_t x;
    x.opcode = op; x.task_id = tid; x.start_stamp = s; x.end_stamp = e;
    send_item(x);
  endtask

  // Drain all results, then let the block settle before touching registers
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic set_regs(logic [31:0] e0, logic [31:0] e1, logic [31:0] e2,
                          logic [31:0] jit);
    write_cfg(REG_EXP0, e0);
    write_cfg(REG_EXP1, e1);
    write_cfg(REG_EXP2, e2);
    write_cfg(REG_JITTER, jit);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly records near the expected time, some queries and noise
  task automatic random_items(int n);
    logic [1:0]  tid;
    logic [31:0] s, dev;
    int          pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      tid  = 2'($urandom_range(0, 2));
      s    = $urandom;
      if (pick < 55) begin
        dev = sb.expect_cyc[tid] + sb.jitter + $urandom_range(0, 4) - 2;
        if ($urandom_range(0, 2) == 0) dev = sb.expect_cyc[tid] - $urandom_range(0, 3000);
        send_op(OP_RECORD, tid, s, s + dev);
      end else if (pick < 70) send_op(OP_RECORD, tid, s, $urandom);
      else if (pick < 88) send_op(OP_QUERY, tid, $urandom, $urandom);
      else if (pick < 89) send_op(OP_CLEAR, 2'($urandom_range(0, 3)), $urandom, $urandom);
      else if (pick < 95) send_op(2'($urandom_range(0, 1)), TASK_BAD, $urandom, $urandom);
      else send_op(OP_IDLE, 2'($urandom_range(0, 3)), $urandom, $urandom);
    end
  endtask

  initial begin
    sb = new();
    burst_left = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty query, stamp extremes, wraparound, violation edge, bad task, clear
    send_op(OP_QUERY, 2'd0, '0, '0);
    send_op(OP_RECORD, 2'd0, '0, '0);
    send_op(OP_RECORD, 2'd0, '0, '1);
    send_op(OP_RECORD, 2'd0, '1, '0);
    send_op(OP_RECORD, 2'd1, 32'd100, 32'd100 + 32'd51000);
    send_op(OP_RECORD, 2'd1, 32'd100, 32'd100 + 32'd51001);
    send_op(OP_RECORD, 2'd2, 32'hFFFF_FF00, 32'd20000);
    send_op(OP_QUERY, 2'd0, '1, '1);
    send_op(OP_QUERY, 2'd1, '0, '0);
    send_op(OP_QUERY, 2'd2, '0, '0);
    send_op(OP_RECORD, TASK_BAD, 32'd5, 32'd9);
    send_op(OP_QUERY, TASK_BAD, '0, '0);
    send_op(OP_IDLE, 2'd1, '1, '0);
    send_op(OP_CLEAR, TASK_BAD, '0, '0);
    send_op(OP_QUERY, 2'd0, '0, '0);
    send_op(OP_RECORD, 2'd0, 32'd10, 32'd20);
    send_op(OP_CLEAR, 2'd1, '1, '1);
    send_op(OP_RECORD, 2'd1, 32'd7, 32'd3);
    send_op(OP_QUERY, 2'd1, '0, '0);
    random_items(380);

    // Extremes: zero expectation and zero limit, then all ones
    wait_drained();
    set_regs('0, '0, '0, '0);
    send_op(OP_RECORD, 2'd0, 32'd0, 32'd1);
    send_op(OP_RECORD, 2'd0, 32'd0, 32'd0);
    random_items(400);
    wait_drained();
    set_regs('1, '1, '1, '1);
    send_op(OP_RECORD, 2'd2, 32'd0, '1);
    send_op(OP_QUERY, 2'd2, '0, '0);
    random_items(400);

    // Random settings with small limits
    wait_drained();
    set_regs($urandom_range(0, 100000), $urandom, $urandom_range(0, 500),
             $urandom_range(0, 50));
    random_items(400);

    wait_drained();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
